>>> src/http_request_head_parser_unit_macros.svh
// Assertion macros for the HTTP request head parser.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hrp_pkg.sv
// Types and constants shared by the HTTP request head parser.
// No dependencies.
`timescale 1ns / 1ps
package hrp_pkg;

  localparam int unsigned LINE_SAT = 8192;
  localparam int unsigned METHOD_MAX = 16;
  localparam int unsigned PATH_MAX = 1024;

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7e;

  localparam logic [1:0] CFG_MAX_REQ_LINE = 2'd0;
  localparam logic [1:0] CFG_MAX_HDR_LINE = 2'd1;
  localparam logic [1:0] CFG_MAX_BODY_LEN = 2'd2;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NO_CRLF   = 4'd1,
    ST_LINE_LONG = 4'd2,
    ST_NO_SP1    = 4'd3,
    ST_NO_SP2    = 4'd4,
    ST_METHOD    = 4'd5,
    ST_PATH      = 4'd6,
    ST_VERSION   = 4'd7,
    ST_UNTERM    = 4'd8,
    ST_HDR_LONG  = 4'd9,
    ST_NO_COLON  = 4'd10,
    ST_LEN_EMPTY = 4'd11,
    ST_NOT_NUM   = 4'd12,
    ST_OVER_CAP  = 4'd13,
    ST_TRUNC     = 4'd14
  } status_t;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_VERSION = 3'd2,
    PH_NAME    = 3'd3,
    PH_SKIP    = 3'd4,
    PH_VALUE   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    VE_NONE    = 2'd0,
    VE_NONNUM  = 2'd1,
    VE_OVERCAP = 2'd2
  } val_err_t;

  typedef struct packed {
    phase_t      phase;
    logic        pending_cr;
    logic        done;
    logic [13:0] line_count;
    logic [4:0]  method_count;
    logic [10:0] path_count;
    logic        flag_method;
    logic        flag_path;
    logic        flag_version;
    logic [3:0]  version_index;
    logic [3:0]  name_index;
    logic        name_mismatch;
    val_err_t    value_error;
    logic [16:0] value_accum;
    logic [16:0] body_length;
  } hrp_state_t;

  typedef struct packed {
    logic        emit;
    status_t     status;
    logic [4:0]  method_len;
    logic [10:0] path_len;
    logic [16:0] content_length;
  } hrp_result_t;

  localparam hrp_state_t STATE_RESET = '{
    phase: PH_METHOD, pending_cr: 1'b0, done: 1'b0, line_count: '0,
    method_count: '0, path_count: '0, flag_method: 1'b0, flag_path: 1'b0,
    flag_version: 1'b0, version_index: '0, name_index: '0,
    name_mismatch: 1'b0, value_error: VE_NONE, value_accum: '0, body_length: '0
  };

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "c";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "l";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = "H"; 4'd1: c = "T"; 4'd2: c = "T"; 4'd3: c = "P";
      4'd4: c = "/"; 4'd5: c = "1"; 4'd6: c = ".";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/hrp_core.sv
// Parse state and per-byte update of the request head parser.
// Depends on hrp_pkg.
`timescale 1ns / 1ps
module hrp_core import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  head_byte,
  input  logic        end_of_buffer,
  input  logic [10:0] max_request_line,
  input  logic [12:0] max_header_line,
  input  logic [16:0] max_body_len,
  output hrp_result_t res
);

  hrp_state_t st_r, st_nxt;

  function automatic hrp_state_t value_byte(input hrp_state_t s, input logic [7:0] b,
                                            input logic [16:0] cap);
    logic [20:0] acc;
    hrp_state_t  t;
    t = s;
    acc = 21'(s.value_accum) * 21'd10 + 21'(b - "0");
    if (!s.name_mismatch && s.value_error == VE_NONE) begin
      if (b < "0" || b > "9") begin
        t.value_error = VE_NONNUM;
      end else begin
        t.value_accum = acc[16:0];
        if (acc > 21'(cap)) t.value_error = VE_OVERCAP;
      end
    end
    return t;
  endfunction

  function automatic hrp_state_t line_byte(input hrp_state_t s, input logic [7:0] b,
                                           input logic [16:0] cap);
    logic [7:0] lc;
    hrp_state_t t;
    t = s;
    lc = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
    if (s.line_count < 14'(LINE_SAT)) t.line_count = s.line_count + 14'd1;
    case (s.phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          t.phase = PH_PATH;
        end else begin
          if (s.method_count < 5'(METHOD_MAX + 1)) t.method_count = s.method_count + 5'd1;
          if (!((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))) t.flag_method = 1'b1;
        end
      end
      PH_PATH: begin
        if (b == CH_SP) begin
          t.phase = PH_VERSION;
        end else begin
          if (s.path_count == '0 && b != CH_SLASH) t.flag_path = 1'b1;
          if (b < CH_PRINT_LO || b > CH_PRINT_HI) t.flag_path = 1'b1;
          if (s.path_count < 11'(PATH_MAX + 1)) t.path_count = s.path_count + 11'd1;
        end
      end
      PH_VERSION: begin
        if (s.version_index < 4'd7) begin
          if (b != ver_char(s.version_index)) t.flag_version = 1'b1;
        end else if (s.version_index == 4'd7) begin
          if (b != "0" && b != "1") t.flag_version = 1'b1;
        end else begin
          t.flag_version = 1'b1;
        end
        if (s.version_index < 4'd9) t.version_index = s.version_index + 4'd1;
      end
      PH_NAME: begin
        if (b == CH_COLON) begin
          if (s.name_index != 4'd14) t.name_mismatch = 1'b1;
          t.phase = PH_SKIP;
        end else begin
          if (s.name_index >= 4'd14 || lc != cl_char(s.name_index)) t.name_mismatch = 1'b1;
          if (s.name_index < 4'd15) t.name_index = s.name_index + 4'd1;
        end
      end
      PH_SKIP: begin
        if (b != CH_SP && b != CH_TAB) begin
          t = value_byte(s, b, cap);
          t.line_count = (s.line_count < 14'(LINE_SAT)) ? s.line_count + 14'd1 : s.line_count;
          t.phase = PH_VALUE;
        end
      end
      default: begin
        t = value_byte(s, b, cap);
        t.line_count = (s.line_count < 14'(LINE_SAT)) ? s.line_count + 14'd1 : s.line_count;
      end
    endcase
    return t;
  endfunction

  function automatic hrp_state_t clear_header(input hrp_state_t s);
    hrp_state_t t;
    t = s;
    t.phase = PH_NAME;
    t.line_count = '0;
    t.name_index = '0;
    t.name_mismatch = 1'b0;
    t.value_error = VE_NONE;
    t.value_accum = '0;
    return t;
  endfunction

  hrp_state_t s;
  logic       emit;
  status_t    code;
  logic       in_req;

  always_comb begin
    s = st_r;
    emit = 1'b0;
    code = ST_OK;
    in_req = 1'b0;
    res = '0;
    if (!st_r.done) begin
      if (st_r.pending_cr && head_byte == CH_LF) begin
        s.pending_cr = 1'b0;
        if (s.phase <= PH_VERSION) begin
          emit = 1'b1;
          if (s.line_count > 14'(max_request_line)) code = ST_LINE_LONG;
          else if (s.phase == PH_METHOD) code = ST_NO_SP1;
          else if (s.phase == PH_PATH) code = ST_NO_SP2;
          else if (s.method_count == '0 || s.method_count > 5'(METHOD_MAX) || s.flag_method)
            code = ST_METHOD;
          else if (s.path_count == '0 || s.path_count > 11'(PATH_MAX) || s.flag_path)
            code = ST_PATH;
          else if (s.version_index != 4'd8 || s.flag_version) code = ST_VERSION;
          else begin
            emit = 1'b0;
            s = clear_header(s);
          end
        end else begin
          emit = 1'b1;
          if (s.line_count == '0) code = ST_OK;
          else if (s.line_count > 14'(max_header_line)) code = ST_HDR_LONG;
          else if (s.phase == PH_NAME) code = ST_NO_COLON;
          else if (!s.name_mismatch && s.phase == PH_SKIP) code = ST_LEN_EMPTY;
          else if (!s.name_mismatch && s.value_error == VE_NONNUM) code = ST_NOT_NUM;
          else if (!s.name_mismatch && s.value_error == VE_OVERCAP) code = ST_OVER_CAP;
          else begin
            emit = 1'b0;
            if (!s.name_mismatch) s.body_length = s.value_accum;
            s = clear_header(s);
          end
        end
      end else begin
        if (st_r.pending_cr) begin
          s.pending_cr = 1'b0;
          s = line_byte(s, CH_CR, max_body_len);
        end
        if (head_byte == CH_CR) s.pending_cr = 1'b1;
        else s = line_byte(s, head_byte, max_body_len);
      end
      if (!emit && end_of_buffer) begin
        emit = 1'b1;
        if (s.phase <= PH_VERSION) code = ST_NO_CRLF;
        else if (s.line_count != '0 || s.pending_cr) code = ST_UNTERM;
        else code = ST_TRUNC;
      end
      if (emit) begin
        in_req = s.phase >= PH_NAME;
        res.emit = 1'b1;
        res.status = code;
        res.method_len = in_req ? s.method_count : '0;
        res.path_len = in_req ? s.path_count : '0;
        res.content_length = s.body_length;
        s.done = 1'b1;
      end
    end
    if (end_of_buffer) s = STATE_RESET;
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

>>> src/http_request_head_parser_unit.sv
// A byte is taken into an input register and parsed from there while the output is not
// stalled; its result, if any, is captured in the output register on that parse step.
// Throughput: one byte per cycle while no result is stalled at the output; hrp_core updates its state once per byte.
// Reset: synchronous active-low rst_n clears parse state, handshakes and the limit
// registers (1056, 4096, 65536). Depends on hrp_pkg, hrp_core and http_request_head_parser_unit_macros.svh.
`timescale 1ns / 1ps
`include "http_request_head_parser_unit_macros.svh"
module http_request_head_parser_unit import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_head_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [4:0]  out_method_len,
  output logic [10:0] out_path_len,
  output logic [16:0] out_content_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic        inq_valid_r, inq_valid_nxt;
  logic [7:0]  inq_byte_r;
  logic        inq_eob_r;
  logic        proceed;
  logic        out_valid_r, out_valid_nxt;
  hrp_result_t res;
  hrp_result_t out_r;
  logic [10:0] max_req_r;
  logic [12:0] max_hdr_r;
  logic [16:0] max_body_r;

  assign cfg_ready = 1'b1;
  assign proceed = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || proceed;
  assign inq_valid_nxt = (in_valid && in_ready) || (inq_valid_r && !proceed);
  assign out_valid_nxt = (out_valid_r && !out_ready) || (proceed && res.emit);

  hrp_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (proceed),
    .head_byte        (inq_byte_r),
    .end_of_buffer    (inq_eob_r),
    .max_request_line (max_req_r),
    .max_header_line  (max_hdr_r),
    .max_body_len     (max_body_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      max_req_r   <= 11'd1056;
      max_hdr_r   <= 13'd4096;
      max_body_r  <= 17'd65536;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_REQ_LINE: max_req_r <= cfg_data[10:0];
          CFG_MAX_HDR_LINE: max_hdr_r <= cfg_data[12:0];
          CFG_MAX_BODY_LEN: max_body_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_head_byte;
      inq_eob_r  <= in_end_of_buffer;
    end
    if (proceed && res.emit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_r.status;
  assign out_method_len = out_r.method_len;
  assign out_path_len = out_r.path_len;
  assign out_content_length = out_r.content_length;

  `HRP_ASSERT_NOW(a_ok_has_lengths, out_valid_r && out_r.status == ST_OK,
    out_r.method_len != '0 && out_r.path_len != '0, "ok result without method/path length")
  `HRP_ASSERT_NOW(a_reqline_err_no_len, out_valid_r && out_r.status >= ST_NO_CRLF &&
    out_r.status <= ST_VERSION, out_r.method_len == '0 && out_r.path_len == '0,
    "request line error reports lengths")
  `HRP_ASSERT_NEXT(a_out_drains, out_valid_r && out_ready && !(proceed && res.emit),
    !out_valid_r, "result not dropped after being taken")
  `HRP_ASSERT_NOW(a_no_step_when_stalled, out_valid_r && !out_ready, !proceed,
    "parser advanced while result stalled")

endmodule

>>> bench/http_request_head_parser_unit_test.sv
// Self-checking bench for http_request_head_parser_unit: random and directed request
// heads, byte-level parse predictor, ready/valid stalls. Depends on hrp_pkg and the unit.
`timescale 1ns / 1ps
module http_request_head_parser_unit_test;
  import hrp_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eob;
  } head_req_t;

  typedef struct {
    logic [3:0]  status;
    logic [4:0]  method_len;
    logic [10:0] path_len;
    logic [16:0] content_length;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_head_byte = 8'h00;
  logic in_end_of_buffer = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_status;
  logic [4:0] out_method_len;
  logic [10:0] out_path_len;
  logic [16:0] out_content_length;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_MAX_REQ_LINE;
  logic [16:0] cfg_data = '0;

  http_request_head_parser_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  head_req_t byte_queue[$];
  verdict_t verdict_queue[$];
  byte unsigned head_buf[$];
  int errors = 0, n_bytes = 0, n_heads = 0, n_verdicts = 0;
  logic [14:0] status_seen = '0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  bit quiet = 1'b0, long_hold_req = 1'b0, big_path_done = 1'b0;

  // parse model state and limits
  int unsigned lim_req, lim_hdr, lim_body;
  phase_t ph;
  bit pcr, dn, fm, fp, fv, nmis;
  int unsigned lc, mc, pc, vi, ni, verr, vacc, blen;
  string ver_text = "HTTP/1.";
  string cl_text = "content-length";

  function automatic void clear_parse();
    ph = PH_METHOD; pcr = 0; dn = 0; lc = 0; mc = 0; pc = 0;
    fm = 0; fp = 0; fv = 0; vi = 0; ni = 0; nmis = 0; verr = 0; vacc = 0; blen = 0;
  endfunction

  function automatic void clear_hdr_line();
    ph = PH_NAME; lc = 0; ni = 0; nmis = 0; verr = 0; vacc = 0;
  endfunction

  function automatic void value_digit(logic [7:0] b);
    if (nmis || verr != 0) return;
    if (b < "0" || b > "9") begin
      verr = 1;
      return;
    end
    vacc = vacc * 10 + (b - "0");
    if (vacc > lim_body) verr = 2;
  endfunction

  function automatic void absorb_byte(logic [7:0] c);
    logic [7:0] b;
    b = c;
    if (lc < LINE_SAT) lc++;
    case (ph)
      PH_METHOD: begin
        if (b == CH_SP) ph = PH_PATH;
        else begin
          if (mc < 17) mc++;
          if (!((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))) fm = 1;
        end
      end
      PH_PATH: begin
        if (b == CH_SP) ph = PH_VERSION;
        else begin
          if (pc == 0 && b != CH_SLASH) fp = 1;
          if (b < CH_PRINT_LO || b > CH_PRINT_HI) fp = 1;
          if (pc < PATH_MAX + 1) pc++;
        end
      end
      PH_VERSION: begin
        if (vi < 7) begin
          if (b != ver_text[vi]) fv = 1;
        end else if (vi == 7) begin
          if (b != "0" && b != "1") fv = 1;
        end else fv = 1;
        if (vi < 9) vi++;
      end
      PH_NAME: begin
        if (b == CH_COLON) begin
          if (ni != 14) nmis = 1;
          ph = PH_SKIP;
        end else begin
          if (b >= "A" && b <= "Z") b = b + 8'h20;
          if (ni >= 14 || b != cl_text[ni]) nmis = 1;
          if (ni < 15) ni++;
        end
      end
      PH_SKIP: begin
        if (b != CH_SP && b != CH_TAB) begin
          ph = PH_VALUE;
          value_digit(b);
        end
      end
      default: value_digit(b);
    endcase
  endfunction

  function automatic int close_line();
    if (ph <= PH_VERSION) begin
      if (lc > lim_req) return ST_LINE_LONG;
      if (ph == PH_METHOD) return ST_NO_SP1;
      if (ph == PH_PATH) return ST_NO_SP2;
      if (mc == 0 || mc > METHOD_MAX || fm) return ST_METHOD;
      if (pc == 0 || pc > PATH_MAX || fp) return ST_PATH;
      if (vi != 8 || fv) return ST_VERSION;
      clear_hdr_line();
      return -1;
    end
    if (lc == 0) return ST_OK;
    if (lc > lim_hdr) return ST_HDR_LONG;
    if (ph == PH_NAME) return ST_NO_COLON;
    if (!nmis) begin
      if (ph == PH_SKIP) return ST_LEN_EMPTY;
      if (verr == 1) return ST_NOT_NUM;
      if (verr == 2) return ST_OVER_CAP;
      blen = vacc;
    end
    clear_hdr_line();
    return -1;
  endfunction

  function automatic verdict_t make_verdict(int st);
    verdict_t v;
    bit acc;
    acc = ph >= PH_NAME;
    v.status = st[3:0];
    v.method_len = acc ? mc[4:0] : '0;
    v.path_len = acc ? pc[10:0] : '0;
    v.content_length = blen[16:0];
    dn = 1;
    return v;
  endfunction

  function automatic bit predict_byte(logic [7:0] b, logic eob, output verdict_t v);
    int st;
    bit hit;
    st = -1;
    hit = 0;
    if (!dn) begin
      if (pcr && b == CH_LF) begin
        pcr = 0;
        st = close_line();
      end else begin
        if (pcr) begin
          pcr = 0;
          absorb_byte(CH_CR);
        end
        if (b == CH_CR) pcr = 1;
        else absorb_byte(b);
      end
      if (st >= 0) begin
        v = make_verdict(st);
        hit = 1;
      end else if (eob) begin
        if (ph <= PH_VERSION) v = make_verdict(ST_NO_CRLF);
        else if (lc != 0 || pcr) v = make_verdict(ST_UNTERM);
        else v = make_verdict(ST_TRUNC);
        hit = 1;
      end
    end
    if (eob) clear_parse();
    return hit;
  endfunction

  // driver
  int tx_gap = 0;
  always @(posedge clk) begin
    head_req_t r;
    verdict_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_head_byte <= 8'h00;
      in_end_of_buffer <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_bytes++;
        if (predict_byte(in_head_byte, in_end_of_buffer, v))
          verdict_queue.insert(verdict_queue.size(), v);
      end
      if (in_valid && !in_ready) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap = $urandom_range(1, 18) - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        r = byte_queue.pop_front();
        in_valid <= 1'b1;
        in_head_byte <= r.b;
        in_end_of_buffer <= r.eob;
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int rx_gap = 0, rx_hold = 0;
  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        if (verdict_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict status %0d", $time, out_status);
        end else begin
          e = verdict_queue.pop_front();
          n_verdicts++;
          status_seen[out_status] = 1'b1;
          if (out_status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          end
          if (out_method_len !== e.method_len) begin
            errors++;
            $display("%0t: method_len expected %0d actual %0d", $time, e.method_len,
                     out_method_len);
          end
          if (out_path_len !== e.path_len) begin
            errors++;
            $display("%0t: path_len expected %0d actual %0d", $time, e.path_len,
                     out_path_len);
          end
          if (out_content_length !== e.content_length) begin
            errors++;
            $display("%0t: content_length expected %0d actual %0d", $time,
                     e.content_length, out_content_length);
          end
        end
      end
      if (long_hold_req && rx_hold == 0) begin
        long_hold_req = 1'b0;
        rx_hold = 300;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck = 0;
    else if (++stuck >= 20000) begin
      $display("http_request_head_parser_unit: mismatch");
      $finish;
    end
  end

  task automatic put_byte(byte unsigned c);
    head_buf.insert(head_buf.size(), c);
  endtask

  task automatic put_text(string t);
    for (int i = 0; i < t.len(); i++) put_byte(t[i]);
  endtask

  task automatic put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  function automatic byte unsigned any_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range("a", "z"));
    return 8'($urandom_range("A", "Z"));
  endfunction

  // queue the build buffer up to byte cut, eob on that byte; later bytes are dropped
  task automatic flush_head(int cut);
    head_req_t r;
    for (int i = 0; i <= cut; i++) begin
      r.b = head_buf[i];
      r.eob = (i == cut);
      byte_queue.insert(byte_queue.size(), r);
    end
    head_buf.delete();
    n_heads++;
  endtask

  task automatic put_head_text(string t);
    put_text(t);
    flush_head(head_buf.size() - 1);
  endtask

  task automatic add_random_head(bit allow_big);
    int n, nh, r;
    byte unsigned c;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      flush_head(head_buf.size() - 1);
      return;
    end
    // method
    r = $urandom_range(0, 99);
    n = r < 4 ? 0 : r < 8 ? 17 : r < 12 ? 16 : $urandom_range(1, 7);
    for (int i = 0; i < n; i++) put_byte(any_letter());
    if ($urandom_range(0, 24) == 0) put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 29) != 0) begin
      put_byte(CH_SP);
      // path
      if ($urandom_range(0, 19) != 0) put_byte(CH_SLASH);
      n = (allow_big && !big_path_done && $urandom_range(0, 9) == 0) ? 1024 +
          $urandom_range(0, 1) : $urandom_range(0, 10);
      if (n > 1000) big_path_done = 1'b1;
      repeat (n) put_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
      if ($urandom_range(0, 24) == 0) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 29) != 0) begin
        put_byte(CH_SP);
        put_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
        if ($urandom_range(0, 14) == 0) begin
          if ($urandom_range(0, 1)) put_byte(any_letter());
          else head_buf[head_buf.size() - 1 - $urandom_range(0, 7)] =
                 8'($urandom_range(0, 255));
        end
      end
    end
    put_crlf();
    // header lines
    nh = $urandom_range(0, 3);
    repeat (nh) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        for (int i = 0; i < cl_text.len(); i++) begin
          c = cl_text[i];
          if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
          put_byte(c);
        end
        if ($urandom_range(0, 14) == 0) put_byte(any_letter());
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) put_byte(any_letter());
      end
      if ($urandom_range(0, 19) != 0) begin
        put_byte(CH_COLON);
        n = $urandom_range(0, 2);
        repeat (n) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
        n = $urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 6);
        repeat (n) put_byte(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 14) == 0) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) put_byte(CH_CR);
      end
      put_crlf();
    end
    put_crlf();
    r = $urandom_range(0, 99);
    if (r < 12) flush_head($urandom_range(0, head_buf.size() - 1));
    else begin
      if (r < 22) repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      flush_head(head_buf.size() - 1);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_REQ_LINE: lim_req = val & 32'h7FF;
      CFG_MAX_HDR_LINE: lim_hdr = val & 32'h1FFF;
      default: lim_body = val & 32'h1FFFF;
    endcase
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid || verdict_queue.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  int unsigned phase_req[5] = '{1, 1056, 30, 1, 1056};
  int unsigned phase_hdr[5] = '{1, 4096, 20, 4096, 4096};
  int unsigned phase_body[5] = '{0, 65536, 500, 65536, 65536};

  initial begin
    int goal;
    lim_req = 1056;
    lim_hdr = 4096;
    lim_body = 65536;
    clear_parse();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed heads at reset limits
    put_head_text("a / HTTP/1.0");
    put_byte(8'hFF);
    flush_head(0);
    put_text("G");
    put_crlf();
    flush_head(head_buf.size() - 1);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_MAX_REQ_LINE, phase_req[p]);
      write_reg(CFG_MAX_HDR_LINE, phase_hdr[p]);
      write_reg(CFG_MAX_BODY_LEN, phase_body[p]);
      tx_idle_pct = (p == 2) ? 0 : 10 + 10 * p;
      rx_idle_pct = (p == 1) ? 0 : 30 - 5 * p;
      quiet = (p == 4);
      if (p == 1) long_hold_req = 1'b1;
      goal = n_bytes + byte_queue.size() + (p == 1 ? 540 : 240);
      while (n_bytes + byte_queue.size() < goal) begin
        add_random_head(p == 1);
        if (byte_queue.size() > 64) @(posedge clk);
      end
      drain();
    end
    $display("%0d bytes in %0d heads, %0d verdicts checked; status codes seen %b",
             n_bytes, n_heads, n_verdicts, status_seen);
    if (errors == 0) $display("http_request_head_parser_unit: match");
    else $display("http_request_head_parser_unit: mismatch");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/hrp_pkg.sv
src/hrp_core.sv
src/http_request_head_parser_unit.sv
bench/http_request_head_parser_unit_test.sv
